// ----- rtl/rvc_pkg.sv -----
// shared constants, types and command codes of the real vector convolution block
package rvc_pkg;

    localparam int MAX_LEN     = 32;
    localparam int SAMPLE_BITS = 16;

    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int CFG_W   = 6;
    localparam int CNT_W   = 6;
    localparam int PROD_W  = 2 * SAMPLE_BITS;
    localparam int ACC_W   = PROD_W + $clog2(MAX_LEN);
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ACC_W + 2 * CNT_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] LEN_RESET   = CFG_W'(32);
    localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(63);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEN_A     = 2'd0,
        REG_LEN_B     = 2'd1,
        REG_OUT_LIMIT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_MAC,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic k_init;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic j_last;
        logic k_last;
        logic pipe_empty;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/rvc_ctrl.sv -----
// controller state machine: sequences loads, product walk and result hand-off
module rvc_ctrl import rvc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_cmd     i_in_cmd,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_in_cmd)
                        CMD_LOAD_A: o_cmd.load_a = 1'b1;
                        CMD_LOAD_B: o_cmd.load_b = 1'b1;
                        CMD_COMPUTE: begin
                            o_cmd.start = 1'b1;
                            n_state     = S_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.k_init = 1'b1;
                n_state      = S_MAC;
            end
            S_MAC: begin
                o_cmd.step = 1'b1;
                if (i_stat.j_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.k_last ? S_IDLE : S_INIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/rvc_datapath.sv -----
// datapath: config registers, sample stores, load pointers, multiply-accumulate, result register
module rvc_datapath import rvc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [ACC_W-1:0]       o_conv_value,
    output logic [CNT_W-1:0]       o_out_index,
    output logic [CNT_W-1:0]       o_out_count,
    output logic                   o_final_flag
);

    logic [CFG_W-1:0] r_len_a;
    logic [CFG_W-1:0] r_len_b;
    logic [CFG_W-1:0] r_out_limit;

    logic [SAMPLE_BITS-1:0] r_store_a [MAX_LEN];
    logic [SAMPLE_BITS-1:0] r_store_b [MAX_LEN];
    logic [CNT_W-1:0]       r_fill_a;
    logic [CNT_W-1:0]       r_fill_b;

    logic [CNT_W-1:0] r_k;
    logic [CNT_W-1:0] r_n;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_jhi;

    logic signed [SAMPLE_BITS-1:0] r_opa;
    logic signed [SAMPLE_BITS-1:0] r_opb;
    logic                          r_iv;
    logic signed [PROD_W-1:0]      r_prod;
    logic                          r_pv;
    logic signed [ACC_W-1:0]       r_acc;

    logic             r_out_valid;
    logic [ACC_W-1:0] r_conv_value;
    logic [CNT_W-1:0] r_out_index;
    logic [CNT_W-1:0] r_out_count;
    logic             r_final_flag;

    logic [CNT_W-1:0] la;
    logic [CNT_W-1:0] lb;
    logic [CNT_W-1:0] lim;
    logic [CNT_W:0]   full;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] jlo_w;
    logic [CNT_W-1:0] jhi_w;
    logic [CNT_W-1:0] idx_b_w;
    logic             k_last;

    // zero length reads as one, anything above the store depth saturates
    always_comb begin
        if (r_len_a == '0) la = CNT_W'(1);
        else if (r_len_a > CFG_W'(MAX_LEN)) la = CNT_W'(MAX_LEN);
        else la = r_len_a;
        if (r_len_b == '0) lb = CNT_W'(1);
        else if (r_len_b > CFG_W'(MAX_LEN)) lb = CNT_W'(MAX_LEN);
        else lb = r_len_b;
        lim = (r_out_limit == '0) ? CNT_W'(1) : r_out_limit;
        full = {1'b0, la} + {1'b0, lb} - (CNT_W+1)'(1);
        n_count = ({1'b0, lim} < full) ? lim : full[CNT_W-1:0];
        // j runs over max(0, k-lb+1) .. min(la-1, k)
        jlo_w = (r_k >= lb) ? (r_k - lb + CNT_W'(1)) : '0;
        jhi_w = (r_k < la) ? r_k : (la - CNT_W'(1));
        idx_b_w = r_k - CNT_W'(r_j);
        k_last = (r_k == (r_n - CNT_W'(1)));
    end

    assign o_stat.j_last     = (r_j == r_jhi);
    assign o_stat.k_last     = k_last;
    assign o_stat.pipe_empty = !r_iv && !r_pv;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a     <= LEN_RESET;
            r_len_b     <= LEN_RESET;
            r_out_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LEN_A:     r_len_a     <= i_cfg_data;
                REG_LEN_B:     r_len_b     <= i_cfg_data;
                REG_OUT_LIMIT: r_out_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LEN; i++) begin
                r_store_a[i] <= '0;
                r_store_b[i] <= '0;
            end
            r_fill_a <= '0;
            r_fill_b <= '0;
        end else if (i_cmd.start) begin
            r_fill_a <= '0;
            r_fill_b <= '0;
        end else begin
            if (i_cmd.load_a && (r_fill_a < la)) begin
                r_store_a[r_fill_a[IDX_W-1:0]] <= i_sample;
                r_fill_a <= r_fill_a + CNT_W'(1);
            end
            if (i_cmd.load_b && (r_fill_b < lb)) begin
                r_store_b[r_fill_b[IDX_W-1:0]] <= i_sample;
                r_fill_b <= r_fill_b + CNT_W'(1);
            end
        end
    end

    // output index and product index counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n <= n_count;
            r_k <= '0;
        end else if (i_cmd.emit) begin
            r_k <= r_k + CNT_W'(1);
        end
        if (i_cmd.k_init) begin
            r_j   <= jlo_w[IDX_W-1:0];
            r_jhi <= jhi_w[IDX_W-1:0];
        end else if (i_cmd.step) begin
            r_j <= r_j + IDX_W'(1);
        end
    end

    // operand fetch, product, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_iv <= i_cmd.step;
            r_pv <= r_iv;
        end
        if (i_cmd.step) begin
            r_opa <= r_store_a[r_j];
            r_opb <= r_store_b[idx_b_w[IDX_W-1:0]];
        end
        r_prod <= r_opa * r_opb;
        if (i_cmd.k_init) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_conv_value <= r_acc;
            r_out_index  <= r_k;
            r_out_count  <= r_n;
            r_final_flag <= k_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_conv_value = r_conv_value;
    assign o_out_index  = r_out_index;
    assign o_out_count  = r_out_count;
    assign o_final_flag = r_final_flag;

endmodule

// ----- rtl/real_vector_convolution.sv -----
// top level of the real vector convolution block: controller plus datapath
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser cmd, tdata sample
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata value/index/count, tlast final
// cfg       in   i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// a load item is taken in idle and stores its sample; a compute item starts, then
// for each result the block sets up the walk, steps through the valid products
// (at most 32) one per cycle on the single shared multiplier, drains the
// fetch/multiply/accumulate pipe and hands off the result
// the result register frees the output side: a stalled result only holds the
// emit step, and the next item is taken once the last result is registered
// reset is synchronous, active low; stores, fill pointers, config registers and
// valid flags take their reset values, no clearing pass
module real_vector_convolution import rvc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // [15:0] sample
    input  logic [1:0]             s_axis_tuser,   // [1:0] cmd
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,   // [36:0] conv_value, [42:37] out_index,
                                                   // [48:43] out_count, rest zero
    output logic                   m_axis_tlast    // final_flag
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    logic [ACC_W-1:0] conv_value;
    logic [CNT_W-1:0] out_index;
    logic [CNT_W-1:0] out_count;

    // sequencer: one item at a time, loads in idle, compute walks k and j
    rvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (t_cmd'(s_axis_tuser)),
        .i_stat     (dp_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (dp_cmd)
    );

    // stores, fetch, multiply, accumulate and the result register
    rvc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample     (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_conv_value (conv_value),
        .o_out_index  (out_index),
        .o_out_count  (out_count),
        .o_final_flag (m_axis_tlast)
    );

    // pack result fields from the lowest bit up, zero filled to whole bytes
    assign m_axis_tdata = M_TDATA_W'({out_count, out_index, conv_value});

endmodule
